// ===== sv/xlhs_pkg.sv =====
package xlhs_pkg;

   localparam int INDEX_BITS  = 8;
   localparam int STATUS_BITS = 2;

   // result queue: two entries of headroom so one transfer can push two results
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = 2;
   localparam int COUNT_BITS = 3;

   localparam logic [7:0] LACE_CONTINUE = 8'd255;

   typedef logic [STATUS_BITS-1:0] status_type;

   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_EMPTY      = 2'd1;
   localparam status_type STATUS_LACE_END   = 2'd2;
   localparam status_type STATUS_LEN_EXCEED = 2'd3;

   localparam logic PHASE_IDLE   = 1'b0;
   localparam logic PHASE_LACING = 1'b1;

endpackage

// ===== sv/xiph_lacing_header_splitter.sv =====
// Splits a Xiph-laced codec extradata blob into header extents. One blob byte
// is taken per req transfer, the first with req_starts_blob and the blob
// length; each lacing byte is folded into the length counters in the same
// cycle, so a byte is accepted every clock while req_ready is high. A
// transfer yields zero, one or two results (a completed header plus the
// final header or an error), which go through a four-entry result queue;
// req_ready is high while the queue has two free entries. With rsp_ready
// held high the block sustains one byte per cycle. Error results carry zero
// extents and leave the block idle until the next blob start; trailing
// bytes while idle give nothing.
module xiph_lacing_header_splitter #(
   parameter int LENGTH_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_starts_blob,
   input  logic [LENGTH_BITS-1:0] req_blob_length,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_header_index,
   output logic [LENGTH_BITS-1:0] rsp_header_length,
   output logic [LENGTH_BITS-1:0] rsp_payload_offset,
   output logic                   rsp_final_header,
   output logic [1:0]             rsp_status
);

   logic                   phase_ff, phase_in;
   logic [7:0]             total_ff, total_in;
   logic [7:0]             index_ff, index_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [LENGTH_BITS-1:0] sum_ff, sum_in;
   logic [LENGTH_BITS-1:0] partial_ff, partial_in;

   logic [LENGTH_BITS:0]   part_sum;
   logic [LENGTH_BITS-1:0] remain_dec;
   logic [LENGTH_BITS-1:0] avail;
   logic [LENGTH_BITS-1:0] sum_new;
   logic [7:0]             index_next;

   logic [1:0]             n_res;
   logic [7:0]             r0_index, r1_index;
   logic [LENGTH_BITS-1:0] r0_length, r1_length;
   logic [LENGTH_BITS-1:0] r0_offset, r1_offset;
   logic                   r0_final, r1_final;
   xlhs_pkg::status_type   r0_status, r1_status;

   logic [7:0]             idx_mem_ff [xlhs_pkg::FIFO_DEPTH];
   logic [LENGTH_BITS-1:0] len_mem_ff [xlhs_pkg::FIFO_DEPTH];
   logic [LENGTH_BITS-1:0] off_mem_ff [xlhs_pkg::FIFO_DEPTH];
   logic                   fin_mem_ff [xlhs_pkg::FIFO_DEPTH];
   xlhs_pkg::status_type   sts_mem_ff [xlhs_pkg::FIFO_DEPTH];

   logic [xlhs_pkg::PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, wr_ptr_1;
   logic [xlhs_pkg::PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [xlhs_pkg::COUNT_BITS-1:0] count_ff, count_in;

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] push_n;

   assign req_ready = (count_ff <= xlhs_pkg::COUNT_BITS'(xlhs_pkg::FIFO_DEPTH - 2));
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign push_n    = req_fire ? n_res : 2'd0;

   assign part_sum   = {1'b0, partial_ff} + {{(LENGTH_BITS-7){1'b0}}, req_data_byte};
   assign remain_dec = remain_ff - LENGTH_BITS'(1);
   assign avail      = remain_dec - sum_ff;
   assign sum_new    = sum_ff + part_sum[LENGTH_BITS-1:0];
   assign index_next = index_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      total_in   = total_ff;
      index_in   = index_ff;
      remain_in  = remain_ff;
      sum_in     = sum_ff;
      partial_in = partial_ff;
      n_res      = 2'd0;
      r0_index   = '0;
      r0_length  = '0;
      r0_offset  = '0;
      r0_final   = 1'b0;
      r0_status  = xlhs_pkg::STATUS_OK;
      r1_index   = '0;
      r1_length  = '0;
      r1_offset  = '0;
      r1_final   = 1'b0;
      r1_status  = xlhs_pkg::STATUS_OK;
      if (req_starts_blob) begin
         index_in   = '0;
         sum_in     = '0;
         partial_in = '0;
         if (req_blob_length == '0) begin
            phase_in  = xlhs_pkg::PHASE_IDLE;
            total_in  = '0;
            remain_in = '0;
            r0_status = xlhs_pkg::STATUS_EMPTY;
            n_res     = 2'd1;
         end else begin
            total_in  = req_data_byte;
            remain_in = req_blob_length - LENGTH_BITS'(1);
            if (req_data_byte == 8'd0) begin
               phase_in  = xlhs_pkg::PHASE_IDLE;
               r0_length = req_blob_length - LENGTH_BITS'(1);
               r0_final  = 1'b1;
               n_res     = 2'd1;
            end else if (req_blob_length == LENGTH_BITS'(1)) begin
               phase_in  = xlhs_pkg::PHASE_IDLE;
               r0_status = xlhs_pkg::STATUS_LACE_END;
               n_res     = 2'd1;
            end else begin
               phase_in = xlhs_pkg::PHASE_LACING;
            end
         end
      end else if (phase_ff == xlhs_pkg::PHASE_LACING) begin
         remain_in  = remain_dec;
         partial_in = part_sum[LENGTH_BITS-1:0];
         if (req_data_byte == xlhs_pkg::LACE_CONTINUE) begin
            if ({1'b0, avail} <= part_sum) begin
               phase_in  = xlhs_pkg::PHASE_IDLE;
               r0_status = xlhs_pkg::STATUS_LACE_END;
               n_res     = 2'd1;
            end
         end else if ({1'b0, avail} < part_sum) begin
            phase_in  = xlhs_pkg::PHASE_IDLE;
            r0_status = xlhs_pkg::STATUS_LEN_EXCEED;
            n_res     = 2'd1;
         end else begin
            r0_index   = index_ff;
            r0_length  = part_sum[LENGTH_BITS-1:0];
            r0_offset  = sum_ff;
            sum_in     = sum_new;
            partial_in = '0;
            index_in   = index_next;
            if (index_next == total_ff) begin
               phase_in  = xlhs_pkg::PHASE_IDLE;
               r1_index  = index_next;
               r1_length = remain_dec - sum_new;
               r1_offset = sum_new;
               r1_final  = 1'b1;
               n_res     = 2'd2;
            end else if (remain_dec == sum_new) begin
               phase_in  = xlhs_pkg::PHASE_IDLE;
               r1_status = xlhs_pkg::STATUS_LACE_END;
               n_res     = 2'd2;
            end else begin
               n_res = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= xlhs_pkg::PHASE_IDLE;
         total_ff   <= '0;
         index_ff   <= '0;
         remain_ff  <= '0;
         sum_ff     <= '0;
         partial_ff <= '0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         total_ff   <= total_in;
         index_ff   <= index_in;
         remain_ff  <= remain_in;
         sum_ff     <= sum_in;
         partial_ff <= partial_in;
      end
   end

   // result queue
   assign wr_ptr_1  = wr_ptr_ff + xlhs_pkg::PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + push_n[xlhs_pkg::PTR_BITS-1:0];
   assign rd_ptr_in = rd_ptr_ff + {{(xlhs_pkg::PTR_BITS-1){1'b0}}, rsp_fire};
   assign count_in  = count_ff + {1'b0, push_n} - {2'b00, rsp_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         idx_mem_ff[wr_ptr_ff] <= r0_index;
         len_mem_ff[wr_ptr_ff] <= r0_length;
         off_mem_ff[wr_ptr_ff] <= r0_offset;
         fin_mem_ff[wr_ptr_ff] <= r0_final;
         sts_mem_ff[wr_ptr_ff] <= r0_status;
      end
      if (push_n == 2'd2) begin
         idx_mem_ff[wr_ptr_1] <= r1_index;
         len_mem_ff[wr_ptr_1] <= r1_length;
         off_mem_ff[wr_ptr_1] <= r1_offset;
         fin_mem_ff[wr_ptr_1] <= r1_final;
         sts_mem_ff[wr_ptr_1] <= r1_status;
      end
   end

   assign rsp_header_index   = idx_mem_ff[rd_ptr_ff];
   assign rsp_header_length  = len_mem_ff[rd_ptr_ff];
   assign rsp_payload_offset = off_mem_ff[rd_ptr_ff];
   assign rsp_final_header   = fin_mem_ff[rd_ptr_ff];
   assign rsp_status         = sts_mem_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= xlhs_pkg::COUNT_BITS'(xlhs_pkg::FIFO_DEPTH))
      else $error("result queue overfilled");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         count_ff == $past(count_ff) + {1'b0, $past(push_n)} - {2'b00, $past(rsp_fire)})
      else $error("result queue count lost track");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != xlhs_pkg::STATUS_OK) |->
         (rsp_header_index == '0 && rsp_header_length == '0 &&
          rsp_payload_offset == '0 && !rsp_final_header))
      else $error("error result carries header extent");

   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_fire && n_res != 2'd0 &&
       ((n_res == 2'd1 && (r0_status != xlhs_pkg::STATUS_OK || r0_final)) ||
        (n_res == 2'd2))) |=> phase_ff == xlhs_pkg::PHASE_IDLE)
      else $error("lacing continues after blob end");

endmodule
